[rtl/mmcu_pkg.sv]
// Package for the machine-mode CSR unit.
// Holds command codes, fixed register addresses, field widths and the write request type.
// No dependencies.
package mmcu_pkg;

    localparam int XLEN      = 32;
    localparam int CSR_DEPTH = 4096;
    localparam int ADDR_W    = 12;
    localparam int CMD_W     = 3;
    localparam int PRIV_W    = 2;
    localparam int CAUSE_W   = 5;
    localparam int INC_W     = 8;

    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TRAP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CNT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SHADOW = 3'd5;

    localparam logic [ADDR_W-1:0] A_MSTATUS = 12'h300;
    localparam logic [ADDR_W-1:0] A_MTVEC   = 12'h305;
    localparam logic [ADDR_W-1:0] A_MEPC    = 12'h341;
    localparam logic [ADDR_W-1:0] A_MCAUSE  = 12'h342;
    localparam logic [ADDR_W-1:0] PAIR_HIGH = 12'h080;

    localparam logic [PRIV_W-1:0] PRIV_MACHINE = 2'd3;
    localparam logic [1:0]        RO_CODE      = 2'b11;
    localparam int                MPP_LO       = 11;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_wr_req;

endpackage

[rtl/mmcu_store.sv]
// CSR word store: one write port, two registered read ports.
// Depends on mmcu_pkg for XLEN, ADDR_W and t_wr_req.
module mmcu_store
    import mmcu_pkg::*;
#(
    parameter int CSR_WORDS = CSR_DEPTH
) (
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [XLEN-1:0]   o_rd_data_a,
    output logic [XLEN-1:0]   o_rd_data_b
);

    localparam int IDX_W = $clog2(CSR_WORDS);

    logic [XLEN-1:0] r_mem [CSR_WORDS];
    logic [XLEN-1:0] r_rd_a;
    logic [XLEN-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[IDX_W-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a[IDX_W-1:0]];
            r_rd_b <= r_mem[i_rd_addr_b[IDX_W-1:0]];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

[rtl/machine_mode_csr_unit.sv]
// Top level of the machine-mode CSR unit: command sequencer, privilege state, output register.
// Depends on mmcu_pkg and mmcu_store.
//
// Channel  Dir  Width  Contents
// s_axis   in   104    cmd, csr_addr, src_addr, write_value, trap_cause, current_pc, increment
// m_axis   out  72     read_data, illegal, redirect, next_pc, priv_now
//
// Read, write, trap return and unused codes finish in S_EXEC; counter add and shadow copy
// add a write in S_W2; trap entry adds writes in S_W2 and S_W3. The single write port of
// the store sets these steps. After reset a clearing pass writes zero to all CSR_WORDS
// words with s_axis_tready low. A stalled result waits in r_res; the unit holds in S_WAIT
// until the output register frees.
module machine_mode_csr_unit
    import mmcu_pkg::*;
#(
    parameter int CSR_WORDS = CSR_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] cmd, [14:3] csr_addr, [26:15] src_addr, [58:27] write_value,
    // [63:59] trap_cause, [95:64] current_pc, [103:96] increment
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] read_data, [32] illegal, [33] redirect, [65:34] next_pc,
    // [67:66] priv_now, [71:68] zero
    output logic [71:0]  m_axis_tdata
);

    localparam int IDX_W = $clog2(CSR_WORDS);
    localparam int OUT_W = XLEN + 1 + 1 + XLEN + PRIV_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_W2   = 3'd3;
    localparam logic [2:0] S_W3   = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_clr_idx;
    logic [PRIV_W-1:0] r_priv, n_priv;
    logic              r_m_valid;
    logic [OUT_W-1:0]  r_m_data;

    logic [CMD_W-1:0]   r_cmd;
    logic [ADDR_W-1:0]  r_addr;
    logic [XLEN-1:0]    r_wval;
    logic [CAUSE_W-1:0] r_cause;
    logic [XLEN-1:0]    r_pc;
    logic [INC_W-1:0]   r_inc;

    t_wr_req r_w2, n_w2;
    t_wr_req r_w3, n_w3;
    t_wr_req wr;

    logic [OUT_W-1:0] r_res, n_res;

    logic               accept;
    logic               out_free;
    logic               finish;
    logic [CMD_W-1:0]   in_cmd;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  in_src;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [XLEN-1:0]    rd_a;
    logic [XLEN-1:0]    rd_b;

    logic [XLEN:0]      lo_sum;
    logic [XLEN-1:0]    hi_sum;
    logic               priv_ok;
    logic               read_only;
    logic [XLEN-1:0]    res_rdata;
    logic               res_ill;
    logic               res_redir;
    logic [XLEN-1:0]    res_npc;
    t_wr_req            w1;

    assign in_cmd  = s_axis_tdata[2:0];
    assign in_addr = s_axis_tdata[14:3];
    assign in_src  = s_axis_tdata[26:15];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    always_comb begin
        rd_addr_a = in_addr;
        rd_addr_b = in_addr | PAIR_HIGH;
        unique case (in_cmd)
            CMD_TRAP: begin
                rd_addr_a = A_MSTATUS;
                rd_addr_b = A_MTVEC;
            end
            CMD_RET: begin
                rd_addr_a = A_MSTATUS;
                rd_addr_b = A_MEPC;
            end
            CMD_SHADOW: begin
                rd_addr_a = in_src;
                rd_addr_b = in_src | PAIR_HIGH;
            end
            default: begin
                rd_addr_a = in_addr;
                rd_addr_b = in_addr | PAIR_HIGH;
            end
        endcase
    end

    mmcu_store #(
        .CSR_WORDS(CSR_WORDS)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr        (wr),
        .i_rd_en     (accept),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign lo_sum    = {1'b0, rd_a} + {{(XLEN + 1 - INC_W){1'b0}}, r_inc};
    assign hi_sum    = rd_b + {{(XLEN - 1){1'b0}}, lo_sum[XLEN]};
    assign priv_ok   = (r_addr[9:8] <= r_priv);
    assign read_only = (r_addr[11:10] == RO_CODE);

    always_comb begin
        res_rdata = '0;
        res_ill   = 1'b0;
        res_redir = 1'b0;
        res_npc   = '0;
        n_priv    = r_priv;
        w1        = '0;
        n_w2      = r_w2;
        n_w3      = r_w3;
        if (r_state == S_EXEC) begin
            n_w2 = '0;
            n_w3 = '0;
            unique case (r_cmd)
                CMD_READ: begin
                    if (priv_ok) begin
                        res_rdata = rd_a;
                    end else begin
                        res_ill = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (read_only || !priv_ok) begin
                        res_ill = 1'b1;
                    end else begin
                        w1 = '{en: 1'b1, addr: r_addr, data: r_wval};
                    end
                end
                CMD_TRAP: begin
                    w1 = '{en: 1'b1, addr: A_MSTATUS,
                           data: {rd_a[XLEN-1:MPP_LO+PRIV_W], r_priv, rd_a[MPP_LO-1:0]}};
                    n_w2 = '{en: 1'b1, addr: A_MCAUSE,
                             data: {{(XLEN - CAUSE_W){1'b0}}, r_cause}};
                    n_w3 = '{en: 1'b1, addr: A_MEPC, data: r_pc};
                    res_npc   = rd_b;
                    res_redir = 1'b1;
                    n_priv    = PRIV_MACHINE;
                end
                CMD_RET: begin
                    if (r_priv != PRIV_MACHINE) begin
                        res_ill = 1'b1;
                    end else begin
                        res_npc   = rd_b;
                        res_redir = 1'b1;
                        n_priv    = rd_a[MPP_LO+PRIV_W-1:MPP_LO];
                    end
                end
                CMD_CNT: begin
                    w1   = '{en: 1'b1, addr: r_addr, data: lo_sum[XLEN-1:0]};
                    n_w2 = '{en: 1'b1, addr: r_addr | PAIR_HIGH, data: hi_sum};
                end
                CMD_SHADOW: begin
                    w1   = '{en: 1'b1, addr: r_addr, data: rd_a};
                    n_w2 = '{en: 1'b1, addr: r_addr | PAIR_HIGH, data: rd_b};
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_res = r_res;
        if (r_state == S_EXEC) begin
            n_res = {n_priv, res_npc, res_redir, res_ill, res_rdata};
        end
    end

    always_comb begin
        unique case (r_state)
            S_CLR:   wr = '{en: 1'b1, addr: ADDR_W'(r_clr_idx), data: '0};
            S_EXEC:  wr = w1;
            S_W2:    wr = r_w2;
            S_W3:    wr = r_w3;
            default: wr = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        finish  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                if (r_clr_idx == IDX_W'(CSR_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (n_w2.en) begin
                    n_state = S_W2;
                end else begin
                    finish = 1'b1;
                end
            end
            S_W2: begin
                if (r_w3.en) begin
                    n_state = S_W3;
                end else begin
                    finish = 1'b1;
                end
            end
            S_W3:    finish = 1'b1;
            S_WAIT:  finish = 1'b1;
            default: n_state = S_IDLE;
        endcase
        if (finish) begin
            n_state = out_free ? S_IDLE : S_WAIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_priv    <= PRIV_MACHINE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_priv  <= n_priv;
            if (r_state == S_CLR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (finish && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= in_cmd;
            r_addr  <= in_addr;
            r_wval  <= s_axis_tdata[58:27];
            r_cause <= s_axis_tdata[63:59];
            r_pc    <= s_axis_tdata[95:64];
            r_inc   <= s_axis_tdata[103:96];
        end
        r_w2  <= n_w2;
        r_w3  <= n_w3;
        r_res <= n_res;
        if (finish && out_free) begin
            r_m_data <= n_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(72 - OUT_W){1'b0}}, r_m_data};

endmodule
